[rtl/core/ctc_pkg.sv]
// Shared types, constants and helpers for the contingency table counter.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package ctc_pkg;

  localparam int unsigned FIELD_VARS   = 4;
  localparam int unsigned VIDX_BITS    = $clog2(FIELD_VARS);
  localparam int unsigned TABLE_DEPTH  = 65536;
  localparam int unsigned ADDR_BITS    = $clog2(TABLE_DEPTH);
  localparam int unsigned COUNT_BITS   = 32;
  localparam int unsigned OUT_BITS     = 32;
  localparam int unsigned VAL_BITS     = 4;
  localparam int unsigned CARD_BITS    = 5;
  localparam int unsigned CARD_MAX     = 16;
  localparam int unsigned MASK_BITS    = FIELD_VARS;
  localparam int unsigned KEY_BITS     = VAL_BITS * FIELD_VARS;
  localparam int unsigned CMP_BITS     = ((ADDR_BITS > KEY_BITS) ? ADDR_BITS : KEY_BITS) + 1;
  localparam int unsigned IDX_BITS     = 3;
  localparam int unsigned CFG_DATA_BITS = CARD_BITS;

  typedef logic [VAL_BITS-1:0]   val_t;
  typedef logic [CARD_BITS-1:0]  card_t;
  typedef logic [ADDR_BITS-1:0]  addr_t;
  typedef logic [COUNT_BITS-1:0] cnt_t;
  typedef logic [KEY_BITS-1:0]   key_t;

  localparam cnt_t COUNT_MAX = '1;

  typedef enum logic {
    CMD_ADD   = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef enum logic {
    STATUS_OK    = 1'b0,
    STATUS_RANGE = 1'b1
  } status_e;

  typedef enum logic [IDX_BITS-1:0] {
    REG_CARD_A    = 3'd0,
    REG_CARD_B    = 3'd1,
    REG_CARD_C    = 3'd2,
    REG_CARD_D    = 3'd3,
    REG_KEEP_MASK = 3'd4
  } reg_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_KEY,
    ST_RD,
    ST_WR,
    ST_WALK,
    ST_DRAIN,
    ST_HOLD
  } state_e;

  typedef struct packed {
    card_t [FIELD_VARS-1:0] card;
    logic  [MASK_BITS-1:0]  keep;
  } cfg_t;

  typedef struct packed {
    logic  we;
    logic  re;
    addr_t addr;
    cnt_t  wdata;
  } ram_req_t;

  function automatic card_t eff_card(card_t raw);
    card_t c;
    c = raw;
    if (raw == '0) begin
      c = card_t'(1);
    end else if (raw > card_t'(CARD_MAX)) begin
      c = card_t'(CARD_MAX);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/core/ctc_if.sv]
// Valid/ready channel interfaces for the row/query input and the result output.
// Depends on ctc_pkg for field widths.
`default_nettype none

interface ctc_in_if;
  import ctc_pkg::*;

  logic                valid;
  logic                ready;
  logic                cmd;
  logic [VAL_BITS-1:0] val_a;
  logic [VAL_BITS-1:0] val_b;
  logic [VAL_BITS-1:0] val_c;
  logic [VAL_BITS-1:0] val_d;

  modport source (output valid, cmd, val_a, val_b, val_c, val_d, input ready);
  modport sink   (input valid, cmd, val_a, val_b, val_c, val_d, output ready);
endinterface

interface ctc_out_if;
  import ctc_pkg::*;

  logic                valid;
  logic                ready;
  logic [OUT_BITS-1:0] count;
  logic                status;

  modport source (output valid, count, status, input ready);
  modport sink   (input valid, count, status, output ready);
endinterface

`default_nettype wire

[rtl/core/ctc_cfg_regs.sv]
// Configuration registers: cardinalities and keep mask, with clamped outputs.
// Depends on ctc_pkg.
`default_nettype none

module ctc_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ctc_pkg::IDX_BITS-1:0]     cfg_idx_i,
  input  logic [ctc_pkg::CFG_DATA_BITS-1:0] cfg_wdata_i,
  output ctc_pkg::cfg_t                    cfg_o
);
  import ctc_pkg::*;

  card_t [FIELD_VARS-1:0] card_q;
  logic  [MASK_BITS-1:0]  keep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      card_q <= {FIELD_VARS{card_t'(1)}};
      keep_q <= '1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CARD_A:    card_q[0] <= cfg_wdata_i;
        REG_CARD_B:    card_q[1] <= cfg_wdata_i;
        REG_CARD_C:    card_q[2] <= cfg_wdata_i;
        REG_CARD_D:    card_q[3] <= cfg_wdata_i;
        REG_KEEP_MASK: keep_q    <= cfg_wdata_i[MASK_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < FIELD_VARS; i++) begin
      cfg_o.card[i] = eff_card(card_q[i]);
    end
    cfg_o.keep = keep_q;
  end

endmodule

`default_nettype wire

[rtl/core/ctc_table_ram.sv]
// Single-port count table with registered read.
// Depends on ctc_pkg.
`default_nettype none

module ctc_table_ram (
  input  logic              clk_i,
  input  ctc_pkg::ram_req_t req_i,
  output ctc_pkg::cnt_t     rdata_o
);
  import ctc_pkg::*;

  cnt_t mem [TABLE_DEPTH];
  cnt_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/core/ctc_engine.sv]
// Control engine: clearing pass, key build, read-modify-write and marginal walk.
// Depends on ctc_pkg and ctc_if; drives ctc_table_ram.
`default_nettype none

module ctc_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctc_pkg::cfg_t     cfg_i,
  ctc_in_if.sink            in_ch,
  ctc_out_if.source         out_ch,
  output ctc_pkg::ram_req_t ram_req_o,
  input  ctc_pkg::cnt_t     ram_rdata_i
);
  import ctc_pkg::*;

  state_e                state_q, state_d;
  cmd_e                  cmd_q, cmd_d;
  val_t [FIELD_VARS-1:0] val_q, val_d;
  logic [VIDX_BITS-1:0]  step_q, step_d;
  key_t                  key_q, key_d;
  addr_t                 addr_q, addr_d;
  val_t [FIELD_VARS-1:0] dig_q, dig_d;
  cnt_t                  res_q, res_d;
  status_e               res_st_q, res_st_d;
  logic                  pend_q, pend_d;
  logic                  hit_q, hit_d;
  logic                  out_valid_q, out_valid_d;
  logic [OUT_BITS-1:0]   out_count_q, out_count_d;
  status_e               out_st_q, out_st_d;

  val_t [FIELD_VARS-1:0] in_vals;
  logic                  add_bad, qry_bad;
  logic [FIELD_VARS-1:0] dig_max;
  val_t [FIELD_VARS-1:0] dig_nxt;
  logic                  carry;
  logic                  hit_now;
  logic                  last_cell;
  logic [KEY_BITS+CARD_BITS-1:0] key_prod;
  logic [CMP_BITS-1:0]   key_ext;
  addr_t                 key_addr;
  cnt_t                  cell_inc;
  logic [COUNT_BITS:0]   acc_sum;
  logic [63:0]           res_wide;
  logic [OUT_BITS-1:0]   res_out;

  assign in_vals[0] = in_ch.val_a;
  assign in_vals[1] = in_ch.val_b;
  assign in_vals[2] = in_ch.val_c;
  assign in_vals[3] = in_ch.val_d;

  always_comb begin
    add_bad = 1'b0;
    qry_bad = 1'b0;
    hit_now = 1'b1;
    for (int i = 0; i < FIELD_VARS; i++) begin
      if (card_t'(in_vals[i]) >= cfg_i.card[i]) begin
        add_bad = 1'b1;
        if (cfg_i.keep[i]) begin
          qry_bad = 1'b1;
        end
      end
      if (cfg_i.keep[i] && (dig_q[i] != val_q[i])) begin
        hit_now = 1'b0;
      end
      dig_max[i] = (card_t'(dig_q[i]) == (cfg_i.card[i] - card_t'(1)));
    end
  end

  // mixed-radix increment, last variable least significant
  always_comb begin
    carry = 1'b1;
    for (int i = FIELD_VARS - 1; i >= 0; i--) begin
      dig_nxt[i] = dig_q[i];
      if (carry) begin
        if (dig_max[i]) begin
          dig_nxt[i] = '0;
        end else begin
          dig_nxt[i] = dig_q[i] + val_t'(1);
          carry      = 1'b0;
        end
      end
    end
  end

  assign last_cell = (&dig_max) || (addr_q == addr_t'(TABLE_DEPTH - 1));
  assign key_prod  = (KEY_BITS+CARD_BITS)'(key_q) * (KEY_BITS+CARD_BITS)'(cfg_i.card[step_q])
                   + (KEY_BITS+CARD_BITS)'(val_q[step_q]);
  assign key_ext   = CMP_BITS'(key_q);
  assign key_addr  = key_ext[ADDR_BITS-1:0];
  assign cell_inc  = (ram_rdata_i == COUNT_MAX) ? COUNT_MAX : ram_rdata_i + cnt_t'(1);
  assign acc_sum   = (COUNT_BITS+1)'(res_q) + (COUNT_BITS+1)'(ram_rdata_i);
  assign res_wide  = 64'(res_q);
  assign res_out   = (res_wide > 64'(32'hFFFF_FFFF)) ? '1 : res_wide[OUT_BITS-1:0];

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    val_d       = val_q;
    step_d      = step_q;
    key_d       = key_q;
    addr_d      = addr_q;
    dig_d       = dig_q;
    res_d       = res_q;
    res_st_d    = res_st_q;
    pend_d      = 1'b0;
    hit_d       = 1'b0;
    out_valid_d = out_valid_q && !out_ch.ready;
    out_count_d = out_count_q;
    out_st_d    = out_st_q;
    ram_req_o   = '0;
    in_ch.ready = 1'b0;

    if (pend_q && hit_q) begin
      res_d = acc_sum[COUNT_BITS] ? COUNT_MAX : acc_sum[COUNT_BITS-1:0];
    end

    case (state_q)
      ST_CLEAR: begin
        ram_req_o.we   = 1'b1;
        ram_req_o.addr = addr_q;
        ram_req_o.wdata = '0;
        addr_d = addr_q + addr_t'(1);
        if (addr_q == addr_t'(TABLE_DEPTH - 1)) begin
          addr_d  = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          cmd_d    = cmd_e'(in_ch.cmd);
          val_d    = in_vals;
          key_d    = '0;
          step_d   = '0;
          addr_d   = '0;
          dig_d    = '0;
          res_d    = '0;
          res_st_d = STATUS_OK;
          if ((in_ch.cmd == CMD_ADD) ? add_bad : qry_bad) begin
            res_st_d = STATUS_RANGE;
            state_d  = ST_HOLD;
          end else if (in_ch.cmd == CMD_ADD) begin
            state_d = ST_KEY;
          end else begin
            state_d = ST_WALK;
          end
        end
      end
      ST_KEY: begin
        key_d  = key_prod[KEY_BITS-1:0];
        step_d = step_q + VIDX_BITS'(1);
        if (step_q == VIDX_BITS'(FIELD_VARS - 1)) begin
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        if (key_ext >= CMP_BITS'(TABLE_DEPTH)) begin
          res_st_d = STATUS_RANGE;
          state_d  = ST_HOLD;
        end else begin
          ram_req_o.re   = 1'b1;
          ram_req_o.addr = key_addr;
          state_d        = ST_WR;
        end
      end
      ST_WR: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.addr  = key_addr;
        ram_req_o.wdata = cell_inc;
        res_d           = cell_inc;
        state_d         = ST_HOLD;
      end
      ST_WALK: begin
        ram_req_o.re   = 1'b1;
        ram_req_o.addr = addr_q;
        pend_d         = 1'b1;
        hit_d          = hit_now;
        dig_d          = dig_nxt;
        addr_d         = addr_q + addr_t'(1);
        if (last_cell) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_HOLD;
      end
      ST_HOLD: begin
        if (!out_valid_q || out_ch.ready) begin
          out_valid_d = 1'b1;
          out_count_d = res_out;
          out_st_d    = res_st_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      addr_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    val_q       <= val_d;
    step_q      <= step_d;
    key_q       <= key_d;
    dig_q       <= dig_d;
    res_q       <= res_d;
    res_st_q    <= res_st_d;
    hit_q       <= hit_d;
    out_count_q <= out_count_d;
    out_st_q    <= out_st_d;
  end

  assign out_ch.valid  = out_valid_q;
  assign out_ch.count  = out_count_q;
  assign out_ch.status = out_st_q;

  a_port_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_req_o.we && ram_req_o.re))
    else $error("table read and write in the same cycle");

  a_wr_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WR) |-> ($past(state_q) == ST_RD))
    else $error("cell write without a preceding read");

  a_hold_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HOLD && !out_valid_q) |=> (state_q == ST_IDLE))
    else $error("result not loaded into free output register");

  a_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_st_q == STATUS_RANGE) |-> (out_count_q == '0))
    else $error("dropped row reports nonzero count");

endmodule

`default_nettype wire

[rtl/core/contingency_table_counter.sv]
// Contingency table counter: mixed-radix count table with marginal queries.
// Input channel ctc_in_if carries cmd and four variable states; output channel
// ctc_out_if carries count and status, one result per accepted item.
// Configuration: write enable, register index (0..3 cardinalities, 4 keep
// mask) and data; writes take effect on the next cycle.
// After reset the table is cleared by a pass over all 65536 cells, one cell per
// cycle; no item is accepted during it, configuration writes are.
// Steps from the accepting edge to a valid result:
//   add row         : 4 key steps, table read, table write, load
//   query           : one table read per cell walked, over P cells,
//                     P = product of the four cardinalities; then drain, load
//   value out of range: load only, count 0 and status 1, table untouched
// One item is in flight at a time; an item is not accepted before the last
// one is through. The next item is accepted as soon as the engine is back in
// idle, even while the output register still holds a result. If the receiver
// stalls, the result waits in the output register and a finished next result
// waits in the engine.
`default_nettype none

module contingency_table_counter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ctc_pkg::IDX_BITS-1:0]      cfg_idx_i,
  input  logic [ctc_pkg::CFG_DATA_BITS-1:0] cfg_wdata_i,
  ctc_in_if.sink                            in_ch,
  ctc_out_if.source                         out_ch
);
  import ctc_pkg::*;

  cfg_t     cfg;
  ram_req_t ram_req;
  cnt_t     ram_rdata;

  ctc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  ctc_table_ram u_ram (
    .clk_i  (clk_i),
    .req_i  (ram_req),
    .rdata_o(ram_rdata)
  );

  ctc_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .ram_req_o  (ram_req),
    .ram_rdata_i(ram_rdata)
  );

endmodule

`default_nettype wire
